// ===== rtl/wdf_pkg.sv =====
// Shared types and constants for the waypoint duplicate filter.
`default_nettype none
package wdf_pkg;

	localparam int NUM_POS = 6;
	localparam int POS_W   = 32;
	localparam int JC_W    = 3;
	localparam int CNT_W   = 16;
	localparam int THR_W   = 31;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(105);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [1:0]       KEPT_SAT  = 2'd3;
	localparam logic [1:0]       KEPT_ONE  = 2'd1;

	// Register index is paddr[ADDR_W-1:2].
	localparam logic REG_DUP_THRESHOLD = 1'b0;

	typedef struct packed {
		logic                             keep;
		logic [NUM_POS-1:0][POS_W-1:0]    pos;
		logic [JC_W-1:0]                  joints_used;
		logic [CNT_W-1:0]                 removed;
	} wdf_result_t;

endpackage
`default_nettype wire

// ===== rtl/wdf_lane.sv =====
// One joint lane: absolute difference against the kept position, compared to threshold.
`default_nettype none
module wdf_lane (
	input  wire logic                             active,
	input  wire logic signed [wdf_pkg::POS_W-1:0] cur_pos,
	input  wire logic signed [wdf_pkg::POS_W-1:0] kept_pos,
	input  wire logic        [wdf_pkg::THR_W-1:0] threshold,
	output logic                                  exceed
);

	logic signed [wdf_pkg::POS_W:0] diff;
	logic        [wdf_pkg::POS_W:0] mag;

	always_comb begin
		diff = {cur_pos[wdf_pkg::POS_W-1], cur_pos} - {kept_pos[wdf_pkg::POS_W-1], kept_pos};
		mag  = diff[wdf_pkg::POS_W] ? (~diff + 1'b1) : diff;
		exceed = active && (mag > {{(wdf_pkg::POS_W + 1 - wdf_pkg::THR_W){1'b0}}, threshold});
	end

endmodule
`default_nettype wire

// ===== rtl/wdf_out_buf.sv =====
// Output register with a skid entry so the input side can accept one more result during a stall.
`default_nettype none
module wdf_out_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire wdf_pkg::wdf_result_t push_data,
	output logic                      full,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output wdf_pkg::wdf_result_t      out_data
);

	logic                 ov_q;
	logic                 sv_q;
	wdf_pkg::wdf_result_t out_q;
	wdf_pkg::wdf_result_t skid_q;
	logic                 pop;

	assign pop       = ov_q && !out_stall;
	assign full      = sv_q;
	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (pop) begin
			if (sv_q) begin
				sv_q <= 1'b0;
			end else if (!push) begin
				ov_q <= 1'b0;
			end
		end else if (push) begin
			if (ov_q) begin
				sv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (sv_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (ov_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/waypoint_duplicate_filter_top.sv =====
// Top level: lanes, merge of lane flags, kept-point state, config register, output buffer.
// Latency: a result is valid the cycle after its input transfer unless an earlier
//   result is still held in the output register by out_stall.
// Throughput: one waypoint per cycle while in_stall is low; the lane compares, the
//   flag merge and the kept-state update all finish in the cycle of the transfer.
// in_stall rises only when both the output register and its skid entry hold results.
// Reset: arst_n clears stream state and buffer control, threshold returns to 105.
`default_nettype none
module waypoint_duplicate_filter_top #(
	parameter int MAX_JOINTS = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_0,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_1,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_2,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_3,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_4,
	input  wire logic signed [wdf_pkg::POS_W-1:0]   joint_pos_5,
	input  wire logic        [wdf_pkg::JC_W-1:0]    joints_used,
	input  wire logic                               final_point,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    keep,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_0,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_1,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_2,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_3,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_4,
	output logic signed      [wdf_pkg::POS_W-1:0]   out_pos_5,
	output logic             [wdf_pkg::JC_W-1:0]    out_joints_used,
	output logic             [wdf_pkg::CNT_W-1:0]   removed_total,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [wdf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic        [wdf_pkg::DATA_W-1:0]  pwdata,
	output logic             [wdf_pkg::DATA_W-1:0]  prdata,
	output logic                                    pready
);

	localparam int LANES = (MAX_JOINTS < wdf_pkg::NUM_POS) ? MAX_JOINTS : wdf_pkg::NUM_POS;

	logic [wdf_pkg::THR_W-1:0]   thr_q;
	logic signed [wdf_pkg::POS_W-1:0] kept_pos_q [LANES];
	logic [wdf_pkg::JC_W-1:0]    kept_n_q;
	logic                        in_traj_q;
	logic [1:0]                  kept_cnt_q;
	logic [wdf_pkg::CNT_W-1:0]   removed_q;

	logic signed [wdf_pkg::POS_W-1:0] in_pos [wdf_pkg::NUM_POS];
	logic [LANES-1:0]            lane_exceed;
	logic                        any_exceed;
	logic                        keep_c;
	logic [wdf_pkg::CNT_W-1:0]   removed_c;
	logic                        push;
	logic                        buf_full;
	wdf_pkg::wdf_result_t        res_in;
	wdf_pkg::wdf_result_t        res_out;
	logic                        cfg_wr;

	assign in_pos[0] = joint_pos_0;
	assign in_pos[1] = joint_pos_1;
	assign in_pos[2] = joint_pos_2;
	assign in_pos[3] = joint_pos_3;
	assign in_pos[4] = joint_pos_4;
	assign in_pos[5] = joint_pos_5;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[wdf_pkg::ADDR_W-1] == wdf_pkg::REG_DUP_THRESHOLD) begin
			prdata = {{(wdf_pkg::DATA_W - wdf_pkg::THR_W){1'b0}}, thr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= wdf_pkg::THR_RESET;
		end else if (cfg_wr && paddr[wdf_pkg::ADDR_W-1] == wdf_pkg::REG_DUP_THRESHOLD) begin
			thr_q <= pwdata[wdf_pkg::THR_W-1:0];
		end
	end

	// lanes
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		wdf_lane u_lane (
			.active    (joints_used > wdf_pkg::JC_W'(j)),
			.cur_pos   (in_pos[j]),
			.kept_pos  (kept_pos_q[j]),
			.threshold (thr_q),
			.exceed    (lane_exceed[j])
		);
	end

	// merge: largest difference above threshold iff some lane is above it
	assign any_exceed = |lane_exceed;

	always_comb begin
		keep_c = !in_traj_q || (joints_used != kept_n_q) || any_exceed
			|| (final_point && kept_cnt_q == wdf_pkg::KEPT_ONE);
		removed_c = removed_q;
		if (!keep_c && removed_q != wdf_pkg::CNT_MAX) begin
			removed_c = removed_q + 1'b1;
		end
	end

	assign in_stall = buf_full;
	assign push     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_n_q   <= '0;
			in_traj_q  <= 1'b0;
			kept_cnt_q <= '0;
			removed_q  <= '0;
		end else if (push) begin
			if (final_point) begin
				kept_n_q   <= '0;
				in_traj_q  <= 1'b0;
				kept_cnt_q <= '0;
				removed_q  <= '0;
			end else begin
				removed_q <= removed_c;
				if (keep_c) begin
					kept_n_q  <= joints_used;
					in_traj_q <= 1'b1;
					if (kept_cnt_q != wdf_pkg::KEPT_SAT) begin
						kept_cnt_q <= kept_cnt_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && keep_c) begin
			for (int j = 0; j < LANES; j++) begin
				kept_pos_q[j] <= in_pos[j];
			end
		end
	end

	always_comb begin
		res_in.keep        = keep_c;
		for (int j = 0; j < wdf_pkg::NUM_POS; j++) begin
			res_in.pos[j] = in_pos[j];
		end
		res_in.joints_used = joints_used;
		res_in.removed     = removed_c;
	end

	wdf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_in),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign keep            = res_out.keep;
	assign out_pos_0       = res_out.pos[0];
	assign out_pos_1       = res_out.pos[1];
	assign out_pos_2       = res_out.pos[2];
	assign out_pos_3       = res_out.pos[3];
	assign out_pos_4       = res_out.pos[4];
	assign out_pos_5       = res_out.pos[5];
	assign out_joints_used = res_out.joints_used;
	assign removed_total   = res_out.removed;

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && final_point) |=> (!in_traj_q && removed_q == '0 && kept_cnt_q == '0))
		else $error("stream state not cleared after final point");

	a_kept_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !final_point && keep_c) |=> (removed_q == $past(removed_q)))
		else $error("removed count changed on a kept waypoint");

	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !in_traj_q) |-> res_in.keep)
		else $error("first waypoint of a trajectory not kept");

endmodule
`default_nettype wire
